FILE: src/jvae_pkg.sv
// Package for the joint velocity/acceleration estimator.
// Field widths, fixed-point sizes, control structs, FSM states and tap helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jvae_pkg;

  localparam int JOINT_W   = 4;
  localparam int POS_W     = 32;
  localparam int INV_W     = 25;
  localparam int COEF_W    = 8;
  localparam int MAC_A_W   = 34;
  localparam int MAC_B_W   = 25;
  localparam int PROD_W    = MAC_A_W + MAC_B_W + 1;
  localparam int ACC_W     = 67;
  localparam int SUM_W     = 41;
  localparam int MAG_W     = 40;
  localparam int MAG_HALF  = MAG_W / 2;
  localparam int CFG_IDX_W = 1;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 72;
  localparam int M_TUSER_W = 2;

  localparam logic [INV_W-1:0]   INV_STEP_RESET = INV_W'(13107);
  localparam logic [JOINT_W-1:0] ACTIVE_RESET   = JOINT_W'(11);

  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_JOINTS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRPOS,
    ST_RD,
    ST_TAP,
    ST_DRAIN,
    ST_ABS,
    ST_SC_LO,
    ST_SC_HI,
    ST_WAIT,
    ST_SAT,
    ST_WRVEL,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic valid;
    logic clear;
    logic shift_hi;
  } mac_op_t;

  typedef struct packed {
    logic               we;
    logic               sel;
    logic [JOINT_W-1:0] joint;
  } win_ctrl_t;

  typedef struct packed {
    logic [JOINT_W-1:0] joint;
    logic [POS_W-1:0]   vel;
    logic               vel_ok;
    logic [POS_W-1:0]   acc;
    logic               acc_ok;
  } result_t;

  // Binomial coefficient by Pascal's rule.
  function automatic int binom(int n, int k);
    int c [16];
    int i;
    int j;
    if (k < 0 || k > n || n > 15) return 0;
    for (i = 0; i < 16; i++) c[i] = 0;
    c[0] = 1;
    for (i = 1; i <= n; i++) begin
      for (j = i; j >= 1; j--) c[j] = c[j] + c[j-1];
    end
    return c[k];
  endfunction

  // Tap k of the smooth differentiator (numerator, scale 2^(2m+1) applied later).
  function automatic int tap_coef(int taps, int k);
    int m;
    m = (taps - 3) >> 1;
    return binom(2 * m, m - k + 1) - binom(2 * m, m - k - 1);
  endfunction

endpackage

`default_nettype wire

FILE: src/joint_velocity_acceleration_estimator_top.sv
// Joint velocity/acceleration estimator, top level. One beat at a time.
// An unused joint goes straight to the output; while windows fill only the position is
// written; otherwise the tap loop and scaling passes run on the shared multiply-accumulate
// unit, once for velocity and once more for acceleration.
// Output register lets the next beat enter while a result waits.
// Reset: fill counters and head pointers cleared, config registers to defaults; windows undefined.
`timescale 1ns / 1ps
`default_nettype none

module joint_velocity_acceleration_estimator_top #(
  parameter int FILTER_TAPS = 5,
  parameter int MAX_JOINTS  = 11
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [jvae_pkg::CFG_IDX_W-1:0]        cfg_addr_i,
  input  logic [jvae_pkg::INV_W-1:0]            cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // joint_index[3:0], position[35:4], zero pad
  input  logic [jvae_pkg::S_TDATA_W-1:0]        s_axis_tdata,
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // result_joint[3:0], velocity[35:4], acceleration[67:36], zero pad
  output logic [jvae_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // velocity_valid[0], acceleration_valid[1]
  output logic [jvae_pkg::M_TUSER_W-1:0]        m_axis_tuser
);
  import jvae_pkg::*;

  localparam int IDX_W = $clog2(FILTER_TAPS);

  logic [INV_W-1:0]   inv_step_q;
  logic [JOINT_W-1:0] active_q;
  logic               out_valid_q;
  result_t            out_q;
  logic               out_free;

  win_ctrl_t            win_ctrl;
  logic [POS_W-1:0]     win_wdata;
  logic [IDX_W-1:0]     rd_off_a;
  logic [IDX_W-1:0]     rd_off_b;
  logic [POS_W-1:0]     rdata_a;
  logic [POS_W-1:0]     rdata_b;
  mac_op_t              mac_op;
  logic signed [MAC_A_W-1:0] mac_a;
  logic [MAC_B_W-1:0]   mac_b;
  logic signed [ACC_W-1:0]   acc;
  logic                 res_load;
  result_t              res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_step_q <= INV_STEP_RESET;
      active_q   <= ACTIVE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_INV_STEP:      inv_step_q <= cfg_wdata_i;
        CFG_ACTIVE_JOINTS: active_q   <= cfg_wdata_i[JOINT_W-1:0];
        default: ;
      endcase
    end
  end

  jvae_ctrl #(
    .FILTER_TAPS(FILTER_TAPS),
    .MAX_JOINTS (MAX_JOINTS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_joint_i     (s_axis_tdata[JOINT_W-1:0]),
    .in_pos_i       (s_axis_tdata[JOINT_W+POS_W-1:JOINT_W]),
    .in_last_i      (s_axis_tlast),
    .inv_step_i     (inv_step_q),
    .active_joints_i(active_q),
    .win_ctrl_o     (win_ctrl),
    .win_wdata_o    (win_wdata),
    .rd_off_a_o     (rd_off_a),
    .rd_off_b_o     (rd_off_b),
    .rdata_a_i      (rdata_a),
    .rdata_b_i      (rdata_b),
    .mac_op_o       (mac_op),
    .mac_a_o        (mac_a),
    .mac_b_o        (mac_b),
    .acc_i          (acc),
    .out_free_i     (out_free),
    .res_load_o     (res_load),
    .res_o          (res)
  );

  jvae_window #(
    .FILTER_TAPS(FILTER_TAPS),
    .MAX_JOINTS (MAX_JOINTS)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (win_ctrl),
    .wdata_i   (win_wdata),
    .rd_off_a_i(rd_off_a),
    .rd_off_b_i(rd_off_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  jvae_mac u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .op_i  (mac_op),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (acc)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(M_TDATA_W - JOINT_W - 2*POS_W)'(0), out_q.acc, out_q.vel,
                          out_q.joint};
  assign m_axis_tuser  = {out_q.acc_ok, out_q.vel_ok};

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  a_acc_needs_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("acceleration valid without velocity");

  a_vel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[JOINT_W+POS_W-1:JOINT_W] == '0)
    else $error("invalid velocity not zero");

  a_acc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |->
      m_axis_tdata[JOINT_W+2*POS_W-1:JOINT_W+POS_W] == '0)
    else $error("invalid acceleration not zero");

endmodule

`default_nettype wire

FILE: src/jvae_window.sv
// Per-joint circular windows for positions and velocities in one memory.
// One write port, two registered read ports, per-window head pointers.
// Depends on jvae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jvae_window #(
  parameter int FILTER_TAPS = 5,
  parameter int MAX_JOINTS  = 11
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  jvae_pkg::win_ctrl_t              ctrl_i,
  input  logic [jvae_pkg::POS_W-1:0]       wdata_i,
  input  logic [$clog2(FILTER_TAPS)-1:0]   rd_off_a_i,
  input  logic [$clog2(FILTER_TAPS)-1:0]   rd_off_b_i,
  output logic [jvae_pkg::POS_W-1:0]       rdata_a_o,
  output logic [jvae_pkg::POS_W-1:0]       rdata_b_o
);
  import jvae_pkg::*;

  localparam int IDX_W  = $clog2(FILTER_TAPS);
  localparam int DEPTH  = 2 * MAX_JOINTS * FILTER_TAPS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int HEADS  = 1 << JOINT_W;

  logic [POS_W-1:0]  mem [DEPTH];
  logic [IDX_W-1:0]  head_q [2][HEADS];
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  head_nxt;
  logic [ADDR_W-1:0] base;
  logic [IDX_W:0]    sum_a;
  logic [IDX_W:0]    sum_b;
  logic [IDX_W-1:0]  phys_a;
  logic [IDX_W-1:0]  phys_b;
  logic [ADDR_W-1:0] addr_w;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;

  assign head     = head_q[ctrl_i.sel][ctrl_i.joint];
  assign head_nxt = (head == IDX_W'(FILTER_TAPS - 1)) ? '0 : head + IDX_W'(1);

  assign base = (ctrl_i.sel ? ADDR_W'(MAX_JOINTS * FILTER_TAPS) : '0)
              + ADDR_W'(int'(ctrl_i.joint) * FILTER_TAPS);

  assign sum_a  = {1'b0, head} + {1'b0, rd_off_a_i};
  assign sum_b  = {1'b0, head} + {1'b0, rd_off_b_i};
  assign phys_a = (sum_a >= (IDX_W+1)'(FILTER_TAPS)) ?
                  IDX_W'(sum_a - (IDX_W+1)'(FILTER_TAPS)) : IDX_W'(sum_a);
  assign phys_b = (sum_b >= (IDX_W+1)'(FILTER_TAPS)) ?
                  IDX_W'(sum_b - (IDX_W+1)'(FILTER_TAPS)) : IDX_W'(sum_b);

  assign addr_w = base + ADDR_W'(head);
  assign addr_a = base + ADDR_W'(phys_a);
  assign addr_b = base + ADDR_W'(phys_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 2; s++) begin
        for (int h = 0; h < HEADS; h++) head_q[s][h] <= '0;
      end
    end else if (ctrl_i.we) begin
      head_q[ctrl_i.sel][ctrl_i.joint] <= head_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) mem[addr_w] <= wdata_i;
    rdata_a_o <= mem[addr_a];
    rdata_b_o <= mem[addr_b];
  end

endmodule

`default_nettype wire

FILE: src/jvae_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate.
// Used for tap sums and for the reciprocal time-step scaling.
// Depends on jvae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jvae_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  jvae_pkg::mac_op_t                   op_i,
  input  logic signed [jvae_pkg::MAC_A_W-1:0] a_i,
  input  logic        [jvae_pkg::MAC_B_W-1:0] b_i,
  output logic signed [jvae_pkg::ACC_W-1:0]   acc_o
);
  import jvae_pkg::*;

  mac_op_t                    op_q;
  logic signed [MAC_B_W:0]    b_ext;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    addend;
  logic signed [ACC_W-1:0]    acc_d;
  logic signed [ACC_W-1:0]    acc_q;

  assign b_ext    = $signed({1'b0, b_i});
  assign prod_d   = a_i * b_ext;
  assign prod_ext = ACC_W'(prod_q);
  assign addend   = op_q.shift_hi ? (prod_ext <<< MAG_HALF) : prod_ext;
  assign acc_d    = (op_q.clear ? '0 : acc_q) + addend;
  assign acc_o    = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '0;
    end else begin
      op_q <= op_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.valid) prod_q <= prod_d;
    if (op_q.valid) acc_q <= acc_d;
  end

endmodule

`default_nettype wire

FILE: src/jvae_ctrl.sv
// Sequencer: window writes, tap loop on the shared MAC, scaling, rounding,
// saturation and frame fill counters. Depends on jvae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jvae_ctrl #(
  parameter int FILTER_TAPS = 5,
  parameter int MAX_JOINTS  = 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [jvae_pkg::JOINT_W-1:0]        in_joint_i,
  input  logic [jvae_pkg::POS_W-1:0]          in_pos_i,
  input  logic                                in_last_i,
  input  logic [jvae_pkg::INV_W-1:0]          inv_step_i,
  input  logic [jvae_pkg::JOINT_W-1:0]        active_joints_i,
  output jvae_pkg::win_ctrl_t                 win_ctrl_o,
  output logic [jvae_pkg::POS_W-1:0]          win_wdata_o,
  output logic [$clog2(FILTER_TAPS)-1:0]      rd_off_a_o,
  output logic [$clog2(FILTER_TAPS)-1:0]      rd_off_b_o,
  input  logic [jvae_pkg::POS_W-1:0]          rdata_a_i,
  input  logic [jvae_pkg::POS_W-1:0]          rdata_b_i,
  output jvae_pkg::mac_op_t                   mac_op_o,
  output logic signed [jvae_pkg::MAC_A_W-1:0] mac_a_o,
  output logic [jvae_pkg::MAC_B_W-1:0]        mac_b_o,
  input  logic signed [jvae_pkg::ACC_W-1:0]   acc_i,
  input  logic                                out_free_i,
  output logic                                res_load_o,
  output jvae_pkg::result_t                   res_o
);
  import jvae_pkg::*;

  localparam int IDX_W = $clog2(FILTER_TAPS);
  localparam int HALF  = (FILTER_TAPS - 1) / 2;
  localparam int K_W   = $clog2(HALF + 1);
  localparam int SH    = 2 * ((FILTER_TAPS - 3) / 2) + 17;
  localparam logic [IDX_W-1:0] FULL  = IDX_W'(FILTER_TAPS - 1);
  localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (SH - 1);

  ctrl_state_e state_q, state_d;

  logic [JOINT_W-1:0] joint_q;
  logic [POS_W-1:0]   pos_q;
  logic               vel_go_q;
  logic               acc_go_q;
  logic               phase_q;
  logic [K_W-1:0]     k_q;
  logic               neg_q;
  logic [MAG_W-1:0]   mag_q;
  logic [POS_W-1:0]   vel_q;
  logic [POS_W-1:0]   accel_q;
  logic [IDX_W-1:0]   pfill_q;
  logic [IDX_W-1:0]   vfill_q;

  logic               accept;
  logic               in_range;
  logic [K_W-1:0]     rd_k;
  logic [COEF_W-1:0]  coef_lut [1:HALF];
  logic signed [MAC_A_W-1:0] ra_ext;
  logic signed [MAC_A_W-1:0] rb_ext;
  logic signed [SUM_W-1:0]   tap_sum;
  logic signed [SUM_W-1:0]   tap_neg;
  logic [ACC_W-1:0]   sum_r;
  logic [ACC_W-1:0]   q;
  logic [POS_W-1:0]   sat_res;

  for (genvar g = 1; g <= HALF; g++) begin : g_coef
    assign coef_lut[g] = COEF_W'(tap_coef(FILTER_TAPS, g));
  end

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign in_range = (in_joint_i < active_joints_i) &&
                    ({1'b0, in_joint_i} < (JOINT_W+1)'(MAX_JOINTS));

  assign ra_ext  = MAC_A_W'($signed(rdata_a_i));
  assign rb_ext  = MAC_A_W'($signed(rdata_b_i));
  assign tap_sum = acc_i[SUM_W-1:0];
  assign tap_neg = -tap_sum;

  // round half up on the magnitude, then clamp to Q16.16 range
  assign sum_r = $unsigned(acc_i) + ROUND;
  assign q     = sum_r >> SH;
  always_comb begin
    if (|q[ACC_W-1:POS_W-1]) begin
      sat_res = neg_q ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      sat_res = neg_q ? -q[POS_W-1:0] : q[POS_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = in_range ? ST_WRPOS : ST_OUT;
      ST_WRPOS: state_d = vel_go_q ? ST_RD : ST_OUT;
      ST_RD:    state_d = ST_TAP;
      ST_TAP:   if (k_q == K_W'(HALF)) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_ABS;
      ST_ABS:   state_d = ST_SC_LO;
      ST_SC_LO: state_d = ST_SC_HI;
      ST_SC_HI: state_d = ST_WAIT;
      ST_WAIT:  state_d = ST_SAT;
      ST_SAT:   state_d = phase_q ? ST_OUT : ST_WRVEL;
      ST_WRVEL: state_d = acc_go_q ? ST_RD : ST_OUT;
      ST_OUT:   if (out_free_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    win_ctrl_o.we    = 1'b0;
    win_ctrl_o.sel   = phase_q;
    win_ctrl_o.joint = joint_q;
    win_wdata_o      = pos_q;
    rd_k             = K_W'(1);
    mac_op_o         = '0;
    mac_a_o          = '0;
    mac_b_o          = inv_step_i;
    res_load_o       = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_WRPOS: begin
        win_ctrl_o.we  = 1'b1;
        win_ctrl_o.sel = 1'b0;
      end
      ST_TAP: begin
        rd_k           = (k_q == K_W'(HALF)) ? k_q : k_q + K_W'(1);
        mac_op_o.valid = 1'b1;
        mac_op_o.clear = (k_q == K_W'(1));
        mac_a_o        = ra_ext - rb_ext;
        mac_b_o        = MAC_B_W'(coef_lut[k_q]);
      end
      ST_SC_LO: begin
        mac_op_o.valid = 1'b1;
        mac_op_o.clear = 1'b1;
        mac_a_o        = MAC_A_W'(mag_q[MAG_HALF-1:0]);
      end
      ST_SC_HI: begin
        mac_op_o.valid    = 1'b1;
        mac_op_o.shift_hi = 1'b1;
        mac_a_o           = MAC_A_W'(mag_q[MAG_W-1:MAG_HALF]);
      end
      ST_WRVEL: begin
        win_ctrl_o.we  = 1'b1;
        win_ctrl_o.sel = 1'b1;
        win_wdata_o    = vel_q;
      end
      ST_OUT:   res_load_o = out_free_i;
      default: ;
    endcase
  end

  assign rd_off_a_o = IDX_W'(HALF) + IDX_W'(rd_k);
  assign rd_off_b_o = IDX_W'(HALF) - IDX_W'(rd_k);

  assign res_o.joint  = joint_q;
  assign res_o.vel    = vel_go_q ? vel_q : '0;
  assign res_o.vel_ok = vel_go_q;
  assign res_o.acc    = acc_go_q ? accel_q : '0;
  assign res_o.acc_ok = acc_go_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      vel_go_q <= 1'b0;
      acc_go_q <= 1'b0;
      phase_q  <= 1'b0;
      k_q      <= '0;
      pfill_q  <= '0;
      vfill_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        vel_go_q <= in_range && (pfill_q == FULL);
        acc_go_q <= in_range && (pfill_q == FULL) && (vfill_q == FULL);
        if (in_last_i) begin
          if (pfill_q < FULL) pfill_q <= pfill_q + IDX_W'(1);
          else if (vfill_q < FULL) vfill_q <= vfill_q + IDX_W'(1);
        end
      end
      if (state_q == ST_WRPOS) phase_q <= 1'b0;
      if (state_q == ST_WRVEL) phase_q <= 1'b1;
      if (state_q == ST_RD) k_q <= K_W'(1);
      else if (state_q == ST_TAP) k_q <= k_q + K_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      joint_q <= in_joint_i;
      pos_q   <= in_pos_i;
    end
    if (state_q == ST_ABS) begin
      neg_q <= tap_sum[SUM_W-1];
      mag_q <= tap_sum[SUM_W-1] ? MAG_W'(tap_neg) : MAG_W'(tap_sum);
    end
    if (state_q == ST_SAT) begin
      if (phase_q) accel_q <= sat_res;
      else vel_q <= sat_res;
    end
  end

endmodule

`default_nettype wire

FILE: sim/joint_rate_checker.sv
// Checker for the joint velocity/acceleration estimator: follows register writes
// and both streams, predicts every result beat and compares it field by field.
// Depends on jvae_pkg.
`timescale 1ns / 1ps

module joint_rate_checker #(
  parameter int TAPS   = 5,
  parameter int JOINTS = 11
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [jvae_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [jvae_pkg::INV_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [jvae_pkg::S_TDATA_W-1:0] in_data_i,
  input  logic                           in_last_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [jvae_pkg::M_TDATA_W-1:0] out_data_i,
  input  logic [jvae_pkg::M_TUSER_W-1:0] out_user_i,
  output int unsigned                    outstanding_o,
  output int unsigned                    fail_count_o
);
  import jvae_pkg::*;

  localparam int HALF  = (TAPS - 1) / 2;
  localparam int ORDER = (TAPS - 3) / 2;
  localparam int SHIFT = 2 * ORDER + 17;
  localparam int FULL  = TAPS - 1;

  typedef logic [TAPS-1:0][POS_W-1:0] window_t;

  window_t            pos_hist [JOINTS];
  window_t            vel_hist [JOINTS];
  int unsigned        pos_frames;
  int unsigned        vel_frames;
  logic [INV_W-1:0]   inv_step;
  logic [JOINT_W-1:0] active;
  result_t            expected_rates [$];
  int unsigned        fails;

  function automatic longint choose(int n, int k);
    longint c;
    int i;
    c = 1;
    if (k < 0 || k > n) return 0;
    for (i = 0; i < k; i++) c = c * (n - i) / (i + 1);
    return c;
  endfunction

  // Central-difference tap sum, scaled by the reciprocal step, rounded half away
  // from zero and clamped to the signed 32-bit range.
  function automatic logic [POS_W-1:0] differentiate_window(window_t w,
                                                             logic [INV_W-1:0] inv);
    longint      sum;
    logic [63:0] mag;
    logic [63:0] q;
    logic        neg;
    int          k;
    sum = 0;
    for (k = 1; k <= HALF; k++)
      sum += (choose(2 * ORDER, ORDER - k + 1) - choose(2 * ORDER, ORDER - k - 1)) *
             (longint'(signed'(w[HALF+k])) - longint'(signed'(w[HALF-k])));
    neg = sum < 0;
    mag = neg ? 64'(-sum) : 64'(sum);
    q   = (mag * 64'(inv) + (64'd1 << (SHIFT - 1))) >> SHIFT;
    if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : POS_W'(-q);
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : POS_W'(q);
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    fails++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t            want;
    result_t            got;
    logic [JOINT_W-1:0] joint;
    int                 n;
    if (!rst_ni) begin
      pos_frames = 0;
      vel_frames = 0;
      inv_step   = INV_STEP_RESET;
      active     = ACTIVE_RESET;
      fails      = 0;
      expected_rates.delete();
      for (n = 0; n < JOINTS; n++) begin
        pos_hist[n] = '0;
        vel_hist[n] = '0;
      end
      outstanding_o <= 0;
      fail_count_o  <= 0;
    end else begin
      // result side first: a beat leaving now never stems from one entering now
      if (out_valid_i && out_ready_i) begin
        got.joint  = out_data_i[JOINT_W-1:0];
        got.vel    = out_data_i[JOINT_W +: POS_W];
        got.acc    = out_data_i[JOINT_W + POS_W +: POS_W];
        got.vel_ok = out_user_i[0];
        got.acc_ok = out_user_i[1];
        if (expected_rates.size() == 0) begin
          flag_mismatch("unexpected beat (expected none), joint", '0, 64'(got.joint));
        end else begin
          want = expected_rates.pop_front();
          if (got.joint !== want.joint)
            flag_mismatch("result_joint", 64'(want.joint), 64'(got.joint));
          if (got.vel !== want.vel)
            flag_mismatch("velocity", 64'(want.vel), 64'(got.vel));
          if (got.vel_ok !== want.vel_ok)
            flag_mismatch("velocity_valid", 64'(want.vel_ok), 64'(got.vel_ok));
          if (got.acc !== want.acc)
            flag_mismatch("acceleration", 64'(want.acc), 64'(got.acc));
          if (got.acc_ok !== want.acc_ok)
            flag_mismatch("acceleration_valid", 64'(want.acc_ok), 64'(got.acc_ok));
        end
      end

      if (in_valid_i && in_ready_i) begin
        joint      = in_data_i[JOINT_W-1:0];
        want       = '0;
        want.joint = joint;
        if (joint < active && joint < JOINTS) begin
          pos_hist[joint] = {in_data_i[JOINT_W +: POS_W], pos_hist[joint][TAPS-1:1]};
          if (pos_frames == FULL) begin
            want.vel        = differentiate_window(pos_hist[joint], inv_step);
            want.vel_ok     = 1'b1;
            vel_hist[joint] = {want.vel, vel_hist[joint][TAPS-1:1]};
            if (vel_frames == FULL) begin
              want.acc    = differentiate_window(vel_hist[joint], inv_step);
              want.acc_ok = 1'b1;
            end
          end
        end
        if (in_last_i) begin
          if (pos_frames < FULL) pos_frames++;
          else if (vel_frames < FULL) vel_frames++;
        end
        expected_rates.push_back(want);
      end

      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_INV_STEP) inv_step = cfg_wdata_i;
        else if (cfg_addr_i == CFG_ACTIVE_JOINTS) active = cfg_wdata_i[JOINT_W-1:0];
      end

      outstanding_o <= expected_rates.size();
      fail_count_o  <= fails;
    end
  end

endmodule

FILE: sim/joint_velocity_acceleration_estimator_top_test.sv
// Testbench top for the joint velocity/acceleration estimator: reset, register
// settings, directed extremes and random frames under varied stream pressure.
// Depends on jvae_pkg, joint_velocity_acceleration_estimator_top and joint_rate_checker.
`timescale 1ns / 1ps

module joint_velocity_acceleration_estimator_top_test;
  import jvae_pkg::*;

  localparam int FILTER_TAPS    = 5;
  localparam int MAX_JOINTS     = 11;
  localparam int FRAMES_TO_FILL = 2 * FILTER_TAPS - 1;
  localparam int PHASE_BEATS    = 145;
  localparam int CYCLE_LIMIT    = 800_000;
  localparam int TAIL_CYCLES    = 64;
  localparam int HOLD_CYCLES    = 400;

  localparam logic [INV_W-1:0]   INV_MAX  = INV_W'(16777216);
  localparam logic [JOINT_W-1:0] ALL_JNTS = JOINT_W'(MAX_JOINTS);
  localparam logic [POS_W-1:0]   POS_MIN  = 32'h8000_0000;
  localparam logic [POS_W-1:0]   POS_MAX  = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SENDER_IDLE,
    FLOW_RECEIVER_STALL,
    FLOW_BOTH
  } flow_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_addr_i;
  logic [INV_W-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  flow_e                flow;
  logic                 hold_req;
  int unsigned          cycles = 0;
  int unsigned          outstanding;
  int unsigned          fail_count;
  logic [POS_W-1:0]     trail [16];

  joint_velocity_acceleration_estimator_top #(
    .FILTER_TAPS(FILTER_TAPS),
    .MAX_JOINTS (MAX_JOINTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  joint_rate_checker #(
    .TAPS  (FILTER_TAPS),
    .JOINTS(MAX_JOINTS)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .outstanding_o(outstanding),
    .fail_count_o (fail_count)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned idle_odds(flow_e f, logic receiver_side);
    case (f)
      FLOW_BOTH:           return 13;
      FLOW_SENDER_IDLE:    return receiver_side ? 0 : 77;
      FLOW_RECEIVER_STALL: return receiver_side ? 77 : 0;
      default:             return 0;
    endcase
  endfunction

  initial begin : receiver
    int unsigned hold_left;
    logic        hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_odds(flow, 1'b1));
      end
    end
  end

  // Random walk per joint, with occasional jumps to arbitrary, rail, zero or all-ones values.
  function automatic logic [POS_W-1:0] next_position(input logic [JOINT_W-1:0] joint);
    case ($urandom_range(7))
      0: trail[joint] = $urandom;
      1: begin
        case ($urandom_range(3))
          0:       trail[joint] = POS_MIN;
          1:       trail[joint] = POS_MAX;
          2:       trail[joint] = '0;
          default: trail[joint] = '1;
        endcase
      end
      default: trail[joint] = trail[joint] + POS_W'($urandom_range(131072)) - POS_W'(65536);
    endcase
    return trail[joint];
  endfunction

  task automatic send_beat(input logic [JOINT_W-1:0] joint, input logic [POS_W-1:0] pos,
                           input logic last);
    while ($urandom_range(99) < idle_odds(flow, 1'b0)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({pos, joint});
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [INV_W-1:0] inv, input logic [JOINT_W-1:0] act);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_INV_STEP;
    cfg_wdata_i <= inv;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_ACTIVE_JOINTS;
    cfg_wdata_i <= INV_W'(act);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // a, a, 0, b, b on joint 0: pushes velocity and acceleration to a rail
  task automatic swing(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
    send_beat('0, a, 1'b0);
    send_beat('0, a, 1'b0);
    send_beat('0, '0, 1'b0);
    send_beat('0, b, 1'b0);
    send_beat('0, b, 1'b0);
  endtask

  task automatic run_phase(input logic [INV_W-1:0] inv, input logic [JOINT_W-1:0] act,
                           input flow_e mode, input logic squeeze);
    int unsigned        counted;
    int unsigned        roll;
    int unsigned        len;
    int unsigned        i;
    logic               paused;
    logic [JOINT_W-1:0] joint;
    drain();
    flow <= mode;
    write_settings(inv, act);
    if (squeeze) hold_req <= 1'b1;
    counted = 0;
    paused  = 1'b0;
    while (counted < PHASE_BEATS) begin
      if (squeeze && !paused && counted >= PHASE_BEATS / 2) begin
        paused = 1'b1;
        drain();
      end
      roll = $urandom_range(99);
      if (roll < 85) begin
        for (i = 0; i < act; i++) begin
          joint = JOINT_W'(i);
          send_beat(joint, next_position(joint), i == act - 1);
        end
        counted += act;
      end else if (roll < 95) begin
        // broken frame: arbitrary joints, early or missing frame end
        len = $urandom_range(act, 1);
        for (i = 0; i < len; i++) begin
          joint = JOINT_W'($urandom_range(15));
          send_beat(joint, next_position(joint), $urandom_range(3) == 0);
          if (joint < act) counted++;
        end
      end else begin
        send_beat(JOINT_W'($urandom_range(15, act)), $urandom, $urandom_range(1));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned f;
    int unsigned k;
    clk_i = 1'b0;
    for (k = 0; k < 16; k++) trail[k] = '0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= CFG_INV_STEP;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    flow          <= FLOW_FREE;
    hold_req      <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_settings(INV_STEP_RESET, ALL_JNTS);
    for (k = 0; k < 3; k++) send_beat(JOINT_W'(MAX_JOINTS + 2 * k), $urandom, 1'b0);
    // full frames until both windows of every joint hold only written entries
    for (f = 0; f < FRAMES_TO_FILL; f++)
      for (k = 0; k < MAX_JOINTS; k++)
        send_beat(JOINT_W'(k), next_position(JOINT_W'(k)), k == MAX_JOINTS - 1);

    drain();
    write_settings(INV_MAX, ALL_JNTS);
    swing(POS_MIN, POS_MAX);
    swing(POS_MAX, POS_MIN);
    send_beat(JOINT_W'(MAX_JOINTS - 1), POS_MAX, 1'b0);
    send_beat(JOINT_W'(MAX_JOINTS), '0, 1'b1);
    send_beat('1, POS_MIN, 1'b1);
    send_beat('0, '0, 1'b1);
    drain();
    write_settings(INV_W'(1), JOINT_W'(1));
    send_beat('0, POS_MAX, 1'b1);
    send_beat(JOINT_W'(1), POS_MIN, 1'b0);
    send_beat('0, '0, 1'b1);
    send_beat('0, '1, 1'b1);

    run_phase(INV_STEP_RESET, ALL_JNTS, FLOW_FREE, 1'b0);
    run_phase(INV_W'($urandom_range(16777216, 1)), JOINT_W'($urandom_range(11, 1)),
              FLOW_SENDER_IDLE, 1'b0);
    run_phase(INV_W'(1), ALL_JNTS, FLOW_RECEIVER_STALL, 1'b1);
    run_phase(INV_MAX, JOINT_W'(1), FLOW_BOTH, 1'b0);
    run_phase(INV_W'($urandom_range(16777216, 1)), JOINT_W'(6), FLOW_SENDER_IDLE, 1'b0);
    run_phase(INV_STEP_RESET, JOINT_W'($urandom_range(11, 1)), FLOW_RECEIVER_STALL, 1'b0);
    run_phase(INV_W'($urandom_range(65536, 1)), ALL_JNTS, FLOW_BOTH, 1'b0);
    run_phase(INV_MAX, ALL_JNTS, FLOW_FREE, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
